/* src/sqcg_pkg.sv */
// Shared constants, types and codes of the sprite quad corner generator.
package sqcg_pkg;

	// Fixed point format of positions, sizes and texture coordinates.
	localparam int FRAC_BITS = 16;

	// Pipelined divider: quotient bits resolved per stage and stage count.
	localparam int DIV_STEP   = 4;
	localparam int DIV_N      = 32 + FRAC_BITS;
	localparam int DIV_STAGES = (DIV_N + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_STAGES * DIV_STEP;
	localparam int LANES      = 4;

	// Width of the rounded sine and cosine.
	localparam int SC_W = FRAC_BITS + 2;

	// Load value of the input pacing counter after each accepted sprite.
	localparam logic [1:0] ITEM_GAP = 2'd3;

	// Flag bit positions.
	localparam int FLAG_SRC_TEXELS = 2;
	localparam int FLAG_DST_PIXELS = 3;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_TEX_W = 1'b0,
		REG_TEX_H = 1'b1
	} cfg_reg_t;

	typedef logic [DIV_W-1:0] div_num_t;
	typedef logic [31:0]      div_den_t;

	// One accepted sprite together with the texture size in use.
	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_w;
		logic signed [31:0] src_h;
		logic signed [31:0] dst_x;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_w;
		logic signed [31:0] dst_h;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [15:0] rotation;
		logic [3:0]         flags;
		logic [14:0]        tw;
		logic [14:0]        th;
	} item_t;

	// Per-sprite values after origin normalization and scaling.
	typedef struct packed {
		logic signed [31:0] dst_x;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_w;
		logic signed [31:0] dst_h;
		logic signed [31:0] org_x;
		logic signed [31:0] org_y;
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_w;
		logic signed [31:0] src_h;
		logic [1:0]         mirror;
	} rec_t;

endpackage

/* src/sprite_quad_corner_generator_core.sv */
// Sprite quad corner generator: four screen and texture corners for each sprite.
// The first corner of a sprite passes through the divider, the per-sprite stages, the sine
// and cosine pipeline and the corner pipeline; the others follow in consecutive cycles.
// After each accepted transaction busy is high and holds off the next one, so that the
// single result port is free for its corners. The receiver cannot stall.
// Reset clears all valid bits and sets both texture size registers to 1.
module sprite_quad_corner_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] src_x,
	input  logic signed [31:0] src_y,
	input  logic signed [31:0] src_w,
	input  logic signed [31:0] src_h,
	input  logic signed [31:0] dst_x,
	input  logic signed [31:0] dst_y,
	input  logic signed [31:0] dst_w,
	input  logic signed [31:0] dst_h,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [15:0] rotation,
	input  logic [3:0]         flags,
	output logic               strobe,
	output logic [1:0]         corner,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic               last
);
	import sqcg_pkg::*;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	function automatic logic [31:0] abs32(logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	// Signed origin quotient from its magnitude, saturated to 32 bits.
	function automatic logic signed [31:0] sat_quo(div_num_t q, logic neg);
		logic signed [31:0] r;
		if (!neg) begin
			r = (|q[DIV_W-1:31]) ? S32_MAX : $signed(q[31:0]);
		end else if ((|q[DIV_W-1:32]) || (q[31] && (|q[30:0]))) begin
			r = S32_MIN;
		end else begin
			r = -$signed(q[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat48(logic signed [47:0] v);
		logic signed [31:0] r;
		if (!v[47] && (|v[46:31])) r = S32_MAX;
		else if (v[47] && !(&v[46:31])) r = S32_MIN;
		else r = v[31:0];
		return r;
	endfunction

	// Texture size registers.
	logic [14:0] tw_q, th_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 15'd1;
			th_q <= 15'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEX_W: tw_q <= cfg_data;
				REG_TEX_H: th_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input pacing: busy holds off a new transaction after each accepted one.
	logic [1:0] gap_q;
	logic       accept;
	assign busy   = (gap_q != 2'd0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= 2'd0;
		else if (accept) gap_q <= ITEM_GAP;
		else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
	end

	// Stage 1: capture the sprite.
	logic  v_s1;
	item_t item_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{src_x: src_x, src_y: src_y, src_w: src_w, src_h: src_h,
				dst_x: dst_x, dst_y: dst_y, dst_w: dst_w, dst_h: dst_h,
				origin_x: origin_x, origin_y: origin_y, rotation: rotation,
				flags: flags, tw: (tw_q == 15'd0) ? 15'd1 : tw_q,
				th: (th_q == 15'd0) ? 15'd1 : th_q};
		end
	end

	// Divider operands: origin over source size, and texture reciprocals.
	div_num_t dnum [LANES];
	div_den_t dden [LANES];
	always_comb begin
		dnum[0] = DIV_W'({abs32(item_s1.origin_x), FRAC_BITS'(0)});
		dnum[1] = DIV_W'({abs32(item_s1.origin_y), FRAC_BITS'(0)});
		dnum[2] = DIV_W'(33'h1_0000_0000);
		dnum[3] = DIV_W'(33'h1_0000_0000);
		dden[0] = (item_s1.src_w == 32'sd0) ? 32'd1 : abs32(item_s1.src_w);
		dden[1] = (item_s1.src_h == 32'sd0) ? 32'd1 : abs32(item_s1.src_h);
		dden[2] = 32'(item_s1.tw);
		dden[3] = 32'(item_s1.th);
	end

	logic     dv;
	item_t    dtag;
	div_num_t dquo [LANES];

	sqcg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s1),
		.in_tag  (item_s1),
		.in_num  (dnum),
		.in_den  (dden),
		.out_v   (dv),
		.out_tag (dtag),
		.out_quo (dquo)
	);

	// Stage 2: saturate the origin, destination size products.
	logic               v_s2;
	item_t              item_s2;
	logic signed [31:0] orgx_s2, orgy_s2;
	logic [32:0]        rcpx_s2, rcpy_s2;
	logic signed [47:0] dwp_s2, dhp_s2;

	// Stage 3: reciprocal scaling products.
	logic               v_s3;
	item_t              item_s3;
	logic signed [31:0] orgx_s3, orgy_s3, dw_s3, dh_s3;
	logic signed [65:0] mx_s3, my_s3, mw_s3, mh_s3;

	// Stage 4: per-sprite values, ready for the angle pipeline.
	logic               v_s4;
	rec_t               rec_s4;
	logic signed [15:0] rot_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= dv;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= dtag;
		orgx_s2 <= sat_quo(dquo[0], dtag.origin_x[31] ^ dtag.src_w[31]);
		orgy_s2 <= sat_quo(dquo[1], dtag.origin_y[31] ^ dtag.src_h[31]);
		rcpx_s2 <= dquo[2][32:0];
		rcpy_s2 <= dquo[3][32:0];
		dwp_s2  <= dtag.dst_w * $signed({1'b0, dtag.tw});
		dhp_s2  <= dtag.dst_h * $signed({1'b0, dtag.th});
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_s2;
		orgx_s3 <= orgx_s2;
		orgy_s3 <= orgy_s2;
		dw_s3   <= item_s2.flags[FLAG_DST_PIXELS] ? item_s2.dst_w : sat48(dwp_s2);
		dh_s3   <= item_s2.flags[FLAG_DST_PIXELS] ? item_s2.dst_h : sat48(dhp_s2);
		mx_s3   <= (item_s2.flags[FLAG_SRC_TEXELS] ? item_s2.src_x : orgx_s2)
			* $signed({1'b0, rcpx_s2});
		my_s3   <= (item_s2.flags[FLAG_SRC_TEXELS] ? item_s2.src_y : orgy_s2)
			* $signed({1'b0, rcpy_s2});
		mw_s3   <= item_s2.src_w * $signed({1'b0, rcpx_s2});
		mh_s3   <= item_s2.src_h * $signed({1'b0, rcpy_s2});
	end

	always_ff @(posedge clk) begin
		rot_s4        <= item_s3.rotation;
		rec_s4.dst_x  <= item_s3.dst_x;
		rec_s4.dst_y  <= item_s3.dst_y;
		rec_s4.dst_w  <= dw_s3;
		rec_s4.dst_h  <= dh_s3;
		rec_s4.mirror <= item_s3.flags[1:0];
		if (item_s3.flags[FLAG_SRC_TEXELS]) begin
			rec_s4.src_x <= mx_s3[63:32];
			rec_s4.src_y <= my_s3[63:32];
			rec_s4.src_w <= mw_s3[63:32];
			rec_s4.src_h <= mh_s3[63:32];
			rec_s4.org_x <= orgx_s3;
			rec_s4.org_y <= orgy_s3;
		end else begin
			rec_s4.src_x <= item_s3.src_x;
			rec_s4.src_y <= item_s3.src_y;
			rec_s4.src_w <= item_s3.src_w;
			rec_s4.src_h <= item_s3.src_h;
			rec_s4.org_x <= mx_s3[63:32];
			rec_s4.org_y <= my_s3[63:32];
		end
	end

	// Sine and cosine of the rotation, with the sprite carried alongside.
	logic                   sc_v;
	logic signed [SC_W-1:0] sc_sin, sc_cos;
	rec_t                   sc_rec;

	sqcg_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s4),
		.in_rot  (rot_s4),
		.in_tag  (rec_s4),
		.out_v   (sc_v),
		.out_sin (sc_sin),
		.out_cos (sc_cos),
		.out_tag (sc_rec)
	);

	// Four corners per sprite.
	sqcg_corner u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (sc_v),
		.in_rec (sc_rec),
		.in_sin (sc_sin),
		.in_cos (sc_cos),
		.strobe (strobe),
		.corner (corner),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.tex_u  (tex_u),
		.tex_v  (tex_v),
		.last   (last)
	);

`ifndef SYNTHESIS
	// An accepted transaction closes the input for the following cycle.
	a_pacing: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("input accepted in back-to-back cycles");

	// Corners of one sprite come out in consecutive cycles and in order.
	a_corner_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (corner == $past(corner) + 2'd1))
		else $error("corner sequence broken");

	// After the fourth corner, a following result starts a new sprite.
	a_corner_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe || (corner == 2'd0))
		else $error("sprite does not start at corner 0");
`endif

endmodule

/* src/sqcg_div.sv */
// Pipelined unsigned restoring divider with four lanes and a tag that travels along.
module sqcg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_v,
	input  sqcg_pkg::item_t     in_tag,
	input  sqcg_pkg::div_num_t  in_num [sqcg_pkg::LANES],
	input  sqcg_pkg::div_den_t  in_den [sqcg_pkg::LANES],
	output logic                out_v,
	output sqcg_pkg::item_t     out_tag,
	output sqcg_pkg::div_num_t  out_quo [sqcg_pkg::LANES]
);
	import sqcg_pkg::*;

	typedef struct packed {
		logic [32:0]      rem;
		logic [DIV_W-1:0] num;
	} lane_t;

	logic     v_s   [DIV_STAGES+1];
	item_t    tag_s [DIV_STAGES+1];
	lane_t    ln_s  [DIV_STAGES+1][LANES];
	div_den_t den_s [DIV_STAGES+1][LANES];

	// DIV_STEP restoring steps; quotient bits shift in at the bottom of num.
	function automatic lane_t div_step(lane_t l, div_den_t d);
		lane_t r;
		r = l;
		for (int i = 0; i < DIV_STEP; i++) begin
			r.rem = {r.rem[31:0], r.num[DIV_W-1]};
			r.num = {r.num[DIV_W-2:0], 1'b0};
			if (r.rem >= {1'b0, d}) begin
				r.rem    = r.rem - {1'b0, d};
				r.num[0] = 1'b1;
			end
		end
		return r;
	endfunction

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= DIV_STAGES; s++) v_s[s] <= 1'b0;
		end else begin
			v_s[0] <= in_v;
			for (int s = 0; s < DIV_STAGES; s++) v_s[s+1] <= v_s[s];
		end
	end

	// Operand load and one group of quotient bits per stage.
	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		for (int l = 0; l < LANES; l++) begin
			ln_s[0][l].rem <= '0;
			ln_s[0][l].num <= in_num[l];
			den_s[0][l]    <= in_den[l];
		end
		for (int s = 0; s < DIV_STAGES; s++) begin
			tag_s[s+1] <= tag_s[s];
			for (int l = 0; l < LANES; l++) begin
				ln_s[s+1][l]  <= div_step(ln_s[s][l], den_s[s][l]);
				den_s[s+1][l] <= den_s[s][l];
			end
		end
	end

	assign out_v   = v_s[DIV_STAGES];
	assign out_tag = tag_s[DIV_STAGES];
	always_comb begin
		for (int l = 0; l < LANES; l++) out_quo[l] = ln_s[DIV_STAGES][l].num;
	end

endmodule

/* src/sqcg_sincos.sv */
// Pipelined sine and cosine by truncated Taylor series, one phase of a term per stage.
module sqcg_sincos (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_v,
	input  logic signed [15:0]          in_rot,
	input  sqcg_pkg::rec_t              in_tag,
	output logic                        out_v,
	output logic signed [sqcg_pkg::SC_W-1:0] out_sin,
	output logic signed [sqcg_pkg::SC_W-1:0] out_cos,
	output sqcg_pkg::rec_t              out_tag
);
	import sqcg_pkg::*;

	localparam int NTERM     = 9;
	localparam int NPH       = 5;
	localparam int NST       = 1 + NPH * NTERM;
	localparam int ANG_SHIFT = 30 - 13;
	localparam int RND_SHIFT = 30 - FRAC_BITS;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [33:0] RND         = 34'sd1 <<< (RND_SHIFT - 1);

	// Term divisors (2n)(2n+1) for sine, (2n-1)(2n) for cosine, and their reciprocals.
	localparam logic [8:0] K_SIN [NTERM] = '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110,
		9'd156, 9'd210, 9'd272, 9'd342};
	localparam logic [8:0] K_COS [NTERM] = '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90,
		9'd132, 9'd182, 9'd240, 9'd306};
	localparam logic [31:0] R_SIN [NTERM] = '{
		32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
		32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
		32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
		32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd272),
		32'((64'd1 << 32) / 64'd342)};
	localparam logic [31:0] R_COS [NTERM] = '{
		32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
		32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
		32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
		32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd240),
		32'((64'd1 << 32) / 64'd306)};

	typedef struct packed {
		logic signed [33:0] sum;
		logic signed [32:0] term;
		logic signed [65:0] prod;
		logic [32:0]        mag;
		logic               psg;
		logic [32:0]        q0;
		logic [33:0]        qk;
	} chan_t;

	typedef struct packed {
		rec_t               tag;
		logic signed [31:0] a;
		logic               neg;
		logic [31:0]        x2;
		chan_t              s;
		chan_t              c;
	} st_t;

	logic v_s  [NST+1];
	st_t  st_s [NST+1];

	// One phase of a term: multiply, magnitude, reciprocal, remainder, correct and add.
	function automatic chan_t chan_step(chan_t ch, logic [31:0] x2, int ph,
		logic [8:0] k, logic [31:0] r);
		chan_t              o;
		logic signed [32:0] xs;
		logic signed [65:0] ap;
		logic [64:0]        qp;
		logic [41:0]        qkw;
		logic [33:0]        rem;
		logic [32:0]        q;
		logic signed [33:0] qs;
		o   = ch;
		xs  = {1'b0, x2};
		ap  = '0;
		qp  = '0;
		qkw = '0;
		rem = '0;
		q   = '0;
		qs  = '0;
		case (ph)
			0: o.prod = ch.term * xs;
			1: begin
				o.psg = ch.prod[65];
				ap    = ch.prod[65] ? -ch.prod : ch.prod;
				o.mag = ap[62:30];
			end
			2: begin
				qp   = ch.mag * r;
				o.q0 = qp[64:32];
			end
			3: begin
				qkw  = ch.q0 * k;
				o.qk = qkw[33:0];
			end
			4: begin
				rem = {1'b0, ch.mag} - ch.qk;
				if (rem >= {k, 1'b0}) q = ch.q0 + 33'd2;
				else if (rem >= 34'(k)) q = ch.q0 + 33'd1;
				else q = ch.q0;
				qs     = {1'b0, q};
				qs     = ch.psg ? qs : -qs;
				o.term = qs[32:0];
				o.sum  = ch.sum + qs;
			end
			default: o = ch;
		endcase
		return o;
	endfunction

	// Stage contents right after the angle fold.
	function automatic st_t load_st(rec_t tag, logic signed [31:0] a, logic neg);
		st_t o;
		o     = '0;
		o.tag = tag;
		o.a   = a;
		o.neg = neg;
		return o;
	endfunction

	// Series start: first sine term is the angle, first cosine term is one.
	function automatic st_t setup_st(st_t i, logic [31:0] x2);
		st_t o;
		o        = i;
		o.x2     = x2;
		o.s.sum  = 34'(i.a);
		o.s.term = 33'(i.a);
		o.c.sum  = ONE_Q30;
		o.c.term = ONE_Q30[32:0];
		return o;
	endfunction

	// One phase of the current term on both channels.
	function automatic st_t term_st(st_t i, int ph, logic [8:0] ks, logic [31:0] rs,
		logic [8:0] kc, logic [31:0] rc);
		st_t o;
		o   = i;
		o.s = chan_step(i.s, i.x2, ph, ks, rs);
		o.c = chan_step(i.c, i.x2, ph, kc, rc);
		return o;
	endfunction

	// Rounding to the output format.
	function automatic logic signed [SC_W-1:0] round_out(logic signed [33:0] v, logic neg);
		logic signed [33:0] t;
		logic signed [SC_W-1:0] r;
		t = (v + RND) >>> RND_SHIFT;
		r = t[SC_W-1:0];
		return neg ? -r : r;
	endfunction

	// Angle to Q2.30 and fold into the half-pi range.
	logic signed [33:0] a_ext;
	logic signed [33:0] a_fold;
	logic               a_neg;
	always_comb begin
		a_ext  = 34'(in_rot) <<< ANG_SHIFT;
		a_fold = a_ext;
		a_neg  = 1'b0;
		if (a_ext > HALF_PI_Q30) begin
			a_fold = a_ext - PI_Q30;
			a_neg  = 1'b1;
		end else if (a_ext < -HALF_PI_Q30) begin
			a_fold = a_ext + PI_Q30;
			a_neg  = 1'b1;
		end
	end

	// Square of the folded angle.
	logic signed [63:0] sq;
	assign sq = st_s[0].a * st_s[0].a;

	// Valid bits of every stage and of the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= NST; s++) v_s[s] <= 1'b0;
			out_v <= 1'b0;
		end else begin
			v_s[0] <= in_v;
			for (int s = 0; s < NST; s++) v_s[s+1] <= v_s[s];
			out_v <= v_s[NST];
		end
	end

	// Fold and series setup stages.
	always_ff @(posedge clk) begin
		st_s[0] <= load_st(in_tag, a_fold[31:0], a_neg);
		st_s[1] <= setup_st(st_s[0], sq[61:30]);
	end

	// Term stages.
	for (genvar g = 1; g < NST; g++) begin : g_term
		localparam int PH = (g - 1) % NPH;
		localparam int TN = (g - 1) / NPH;
		always_ff @(posedge clk) begin
			st_s[g+1] <= term_st(st_s[g], PH, K_SIN[TN], R_SIN[TN], K_COS[TN], R_COS[TN]);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		out_sin <= round_out(st_s[NST].s.sum, st_s[NST].neg);
		out_cos <= round_out(st_s[NST].c.sum, st_s[NST].neg);
		out_tag <= st_s[NST].tag;
	end

endmodule

/* src/sqcg_corner.sv */
// Corner sequencer and per-corner offset, rotation and texture pipeline.
module sqcg_corner (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_v,
	input  sqcg_pkg::rec_t                   in_rec,
	input  logic signed [sqcg_pkg::SC_W-1:0] in_sin,
	input  logic signed [sqcg_pkg::SC_W-1:0] in_cos,
	output logic                             strobe,
	output logic [1:0]                       corner,
	output logic signed [31:0]               pos_x,
	output logic signed [31:0]               pos_y,
	output logic signed [31:0]               tex_u,
	output logic signed [31:0]               tex_v,
	output logic                             last
);
	import sqcg_pkg::*;

	localparam int PW = 32 + SC_W;
	localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

	typedef struct packed {
		rec_t                   rec;
		logic signed [SC_W-1:0] sn;
		logic signed [SC_W-1:0] cs;
	} hold_t;

	typedef struct packed {
		logic [1:0]             idx;
		logic signed [31:0]     dx;
		logic signed [31:0]     dy;
		logic signed [31:0]     u;
		logic signed [31:0]     v;
		logic signed [SC_W-1:0] sn;
		logic signed [SC_W-1:0] cs;
	} side_t;

	hold_t      hold_q;
	logic       act_q;
	logic [1:0] idx_q;

	// Sequencer: a new sprite restarts the corner count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (in_v) begin
			act_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (act_q) begin
			if (idx_q == 2'd3) act_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_v) hold_q <= '{rec: in_rec, sn: in_sin, cs: in_cos};
	end

	// Stage 1: corner offsets from the origin and texture corner.
	logic [1:0] tsel;
	assign tsel = idx_q ^ hold_q.rec.mirror;

	logic               v_s1, v_s2, v_s3, v_s4;
	side_t              sd_s1, sd_s2, sd_s3, sd_s4;
	logic signed [32:0] dxm_s1, dym_s1;
	logic signed [31:0] dw_s1, dh_s1;
	logic signed [64:0] ofx_s2, ofy_s2;
	logic signed [31:0] offx_s3, offy_s3;
	logic signed [PW-1:0] pa_s4, pb_s4, pc_s4, pd_s4;
	logic signed [PW:0] dfx, dfy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s1   <= act_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			strobe <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sd_s1.idx <= idx_q;
		sd_s1.dx  <= hold_q.rec.dst_x;
		sd_s1.dy  <= hold_q.rec.dst_y;
		sd_s1.u   <= hold_q.rec.src_x + (tsel[0] ? hold_q.rec.src_w : 32'sd0);
		sd_s1.v   <= hold_q.rec.src_y + (tsel[1] ? hold_q.rec.src_h : 32'sd0);
		sd_s1.sn  <= hold_q.sn;
		sd_s1.cs  <= hold_q.cs;
		dxm_s1    <= (idx_q[0] ? ONE : 33'sd0) - 33'(hold_q.rec.org_x);
		dym_s1    <= (idx_q[1] ? ONE : 33'sd0) - 33'(hold_q.rec.org_y);
		dw_s1     <= hold_q.rec.dst_w;
		dh_s1     <= hold_q.rec.dst_h;
	end

	// Stage 2: scale by the destination size.
	always_ff @(posedge clk) begin
		sd_s2  <= sd_s1;
		ofx_s2 <= dxm_s1 * dw_s1;
		ofy_s2 <= dym_s1 * dh_s1;
	end

	// Stage 3: back to the fixed point format, wrapping to 32 bits.
	always_ff @(posedge clk) begin
		sd_s3   <= sd_s2;
		offx_s3 <= ofx_s2[FRAC_BITS+31:FRAC_BITS];
		offy_s3 <= ofy_s2[FRAC_BITS+31:FRAC_BITS];
	end

	// Stage 4: rotation products.
	always_ff @(posedge clk) begin
		sd_s4 <= sd_s3;
		pa_s4 <= offx_s3 * sd_s3.cs;
		pb_s4 <= offy_s3 * sd_s3.sn;
		pc_s4 <= offx_s3 * sd_s3.sn;
		pd_s4 <= offy_s3 * sd_s3.cs;
	end

	// Stage 5: rotate, add the anchor and drive the result.
	always_comb begin
		dfx = pa_s4 - pb_s4;
		dfy = pc_s4 + pd_s4;
	end

	always_ff @(posedge clk) begin
		corner <= sd_s4.idx;
		last   <= (sd_s4.idx == 2'd3);
		pos_x  <= sd_s4.dx + dfx[FRAC_BITS+31:FRAC_BITS];
		pos_y  <= sd_s4.dy + dfy[FRAC_BITS+31:FRAC_BITS];
		tex_u  <= sd_s4.u;
		tex_v  <= sd_s4.v;
	end

endmodule

/* test/tb_sprite_quad_corner_generator_core.sv */
// Testbench of the sprite quad corner generator: table-driven and random sprites checked against a predictor.
module tb_sprite_quad_corner_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sqcg_pkg::*;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam int     LATENCY     = 80;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int     N_DIRECTED  = 14;
	localparam int     N_RANDOM    = 246;

	// One sprite as driven on the input ports.
	typedef struct {
		logic signed [31:0] src_x, src_y, src_w, src_h;
		logic signed [31:0] dst_x, dst_y, dst_w, dst_h;
		logic signed [31:0] origin_x, origin_y;
		logic signed [15:0] rotation;
		logic [3:0]         flags;
	} sprite_t;

	// One corner as seen on the result ports.
	typedef struct {
		logic [1:0]  corner;
		logic [31:0] pos_x, pos_y, tex_u, tex_v;
		logic        last;
	} quad_corner_t;

	// Directed row: a sprite, the texture size in force, and an optional typed-in first corner.
	typedef struct {
		sprite_t      spr;
		logic [14:0]  tw, th;
		bit           has_known;
		quad_corner_t known;
	} sprite_row_t;

	logic clk, arst_n, cfg_we, start, busy, strobe, last;
	logic [0:0] cfg_index;
	logic [14:0] cfg_data;
	logic signed [31:0] src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h;
	logic signed [31:0] origin_x, origin_y, pos_x, pos_y, tex_u, tex_v;
	logic signed [15:0] rotation;
	logic [3:0] flags;
	logic [1:0] corner;

	quad_corner_t pending_corners[$];
	longint cycles;
	int mismatches, corners_seen, sprites_sent;
	logic [14:0] cur_tw, cur_th;
	bit no_idle;

	sprite_quad_corner_generator_core dut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle counter with timeout.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("sprite_quad_corner_generator_core test failed");
				$finish;
			end
		end
	end

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap_s32(longint v);
		logic signed [31:0] w;
		w = v[31:0];
		return longint'(w);
	endfunction

	function automatic longint by_recip(longint v, longint size);
		longint recip;
		recip = (64'sd1 << 32) / size;
		return floor_sh(v * recip, 32);
	endfunction

	// Sine and cosine of a Q3.13 angle, rounded to FRAC_BITS fraction bits.
	function automatic void sine_cosine(longint rot, output longint sn, output longint cs);
		longint a, x2, term, s, c;
		logic [63:0] sq;
		bit neg;
		a = rot * 131072;
		neg = 0;
		if (a > HALF_PI_Q30) begin
			a -= PI_Q30;
			neg = 1;
		end else if (a < -HALF_PI_Q30) begin
			a += PI_Q30;
			neg = 1;
		end
		sq = a * a;
		x2 = longint'(sq >> 30);
		term = a;
		s = a;
		for (int n = 1; n <= 9; n++) begin
			term = -(term * x2) / (longint'((2 * n) * (2 * n + 1)) * ONE_Q30);
			s += term;
		end
		term = ONE_Q30;
		c = ONE_Q30;
		for (int n = 1; n <= 9; n++) begin
			term = -(term * x2) / (longint'((2 * n - 1) * (2 * n)) * ONE_Q30);
			c += term;
		end
		s = floor_sh(s + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
		c = floor_sh(c + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
		sn = neg ? -s : s;
		cs = neg ? -c : c;
	endfunction

	// Compute the four corners of a sprite and queue them.
	task automatic predict_corners(sprite_t sp, logic [14:0] twr, logic [14:0] thr);
		longint tw, th, sx, sy, sw, sh, dw, dh, ox, oy, sn, cs, one;
		longint offx, offy, px, py, u, v;
		logic [1:0] mirror, t;
		quad_corner_t qc;
		one = 64'sd1 << FRAC_BITS;
		tw = (twr == 0) ? 1 : twr;
		th = (thr == 0) ? 1 : thr;
		sx = sp.src_x; sy = sp.src_y; sw = sp.src_w; sh = sp.src_h;
		dw = sp.dst_w; dh = sp.dst_h;
		mirror = sp.flags[1:0];
		ox = sat_s32((longint'(sp.origin_x) * one) / (sw != 0 ? sw : 1));
		oy = sat_s32((longint'(sp.origin_y) * one) / (sh != 0 ? sh : 1));
		if (sp.flags[FLAG_SRC_TEXELS]) begin
			sx = by_recip(sx, tw); sy = by_recip(sy, th);
			sw = by_recip(sw, tw); sh = by_recip(sh, th);
		end else begin
			ox = by_recip(ox, tw); oy = by_recip(oy, th);
		end
		if (!sp.flags[FLAG_DST_PIXELS]) begin
			dw = sat_s32(dw * tw);
			dh = sat_s32(dh * th);
		end
		sine_cosine(sp.rotation, sn, cs);
		for (int i = 0; i < 4; i++) begin
			offx = wrap_s32(floor_sh((longint'(i & 1) * one - ox) * dw, FRAC_BITS));
			offy = wrap_s32(floor_sh((longint'(i >> 1) * one - oy) * dh, FRAC_BITS));
			px = longint'(sp.dst_x) + floor_sh(offx * cs - offy * sn, FRAC_BITS);
			py = longint'(sp.dst_y) + floor_sh(offx * sn + offy * cs, FRAC_BITS);
			t = 2'(i) ^ mirror;
			u = sx + (t[0] ? sw : 0);
			v = sy + (t[1] ? sh : 0);
			qc.corner = 2'(i);
			qc.pos_x = px[31:0];
			qc.pos_y = py[31:0];
			qc.tex_u = u[31:0];
			qc.tex_v = v[31:0];
			qc.last = (i == 3);
			pending_corners.insert(pending_corners.size(), qc);
		end
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 'h1ffffff)) - 'h1000000);
		endcase
	endfunction

	function automatic sprite_t rand_sprite();
		sprite_t s;
		s.src_x = rand_q(); s.src_y = rand_q(); s.src_w = rand_q(); s.src_h = rand_q();
		s.dst_x = rand_q(); s.dst_y = rand_q(); s.dst_w = rand_q(); s.dst_h = rand_q();
		s.origin_x = rand_q(); s.origin_y = rand_q();
		s.rotation = ($urandom_range(0, 5) == 0) ? 16'sd0 : 16'($urandom);
		s.flags = 4'($urandom);
		return s;
	endfunction

	function automatic sprite_t make_sprite(logic [31:0] sw, logic [31:0] dwh, logic [31:0] org,
			logic [15:0] rot, logic [3:0] fl);
		sprite_t s;
		s.src_x = 32'h0001_0000; s.src_y = 32'h0002_0000; s.src_w = sw; s.src_h = sw;
		s.dst_x = 32'h0010_0000; s.dst_y = 32'h0020_0000; s.dst_w = dwh; s.dst_h = dwh;
		s.origin_x = org; s.origin_y = org; s.rotation = rot; s.flags = fl;
		return s;
	endfunction

	// Compare each corner with the oldest expectation.
	always @(posedge clk) begin
		quad_corner_t exp_c;
		if (arst_n && strobe) begin
			corners_seen++;
			if (pending_corners.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected corner %0d", corner);
			end else begin
				exp_c = pending_corners.pop_front();
				if (corner !== exp_c.corner || pos_x !== exp_c.pos_x || pos_y !== exp_c.pos_y
						|| tex_u !== exp_c.tex_u || tex_v !== exp_c.tex_v
						|| last !== exp_c.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: exp c%0d %h %h %h %h l%0b, got c%0d %h %h %h %h l%0b",
							exp_c.corner, exp_c.pos_x, exp_c.pos_y, exp_c.tex_u, exp_c.tex_v,
							exp_c.last, corner, pos_x, pos_y, tex_u, tex_v, last);
				end
			end
		end
	end

	// One register write; the write port is released again before the task returns.
	task automatic write_reg(cfg_reg_t idx, logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TEX_W) cur_tw = val;
		else cur_th = val;
		@(negedge clk);
	endtask

	// Close the input, then wait for all queued corners plus the latency.
	task automatic drain();
		start <= 1'b0;
		while (pending_corners.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// Present one sprite and hold it until accepted; start stays high for the next one.
	task automatic send_sprite(sprite_t s);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		src_x <= s.src_x; src_y <= s.src_y; src_w <= s.src_w; src_h <= s.src_h;
		dst_x <= s.dst_x; dst_y <= s.dst_y; dst_w <= s.dst_w; dst_h <= s.dst_h;
		origin_x <= s.origin_x; origin_y <= s.origin_y;
		rotation <= s.rotation; flags <= s.flags;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_corners(s, cur_tw, cur_th);
		sprites_sent++;
		@(negedge clk);
	endtask

	sprite_row_t rows[N_DIRECTED];

	initial begin
		sprite_row_t r;
		int row_corners;
		logic [14:0] tws[5] = '{15'd1, 15'd16384, 15'd0, 15'd32767, 15'd256};
		mismatches = 0; corners_seen = 0; sprites_sent = 0; no_idle = 0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = REG_TEX_W; cfg_data = '0; start = 1'b0;
		src_x = '0; src_y = '0; src_w = '0; src_h = '0; dst_x = '0; dst_y = '0;
		dst_w = '0; dst_h = '0; origin_x = '0; origin_y = '0; rotation = '0; flags = '0;
		cur_tw = 15'd1; cur_th = 15'd1;

		// Directed table: extremes, every flag, zero sizes, rotation limits.
		for (int i = 0; i < N_DIRECTED; i++) begin
			rows[i].tw = 15'd1; rows[i].th = 15'd1; rows[i].has_known = 0;
		end
		rows[0].spr = make_sprite(32'h0001_0000, 32'h0001_0000, 32'h0, 16'sd0, 4'b1000);
		rows[0].has_known = 1;
		rows[0].known = '{2'd0, 32'h0010_0000, 32'h0020_0000, 32'h0001_0000, 32'h0002_0000, 1'b0};
		rows[1].spr = make_sprite(32'h0001_0000, 32'h0001_0000, 32'h0, 16'sd0, 4'b0001);
		rows[2].spr = make_sprite(32'h0001_0000, 32'h0001_0000, 32'h0, 16'sd0, 4'b0010);
		rows[3].spr = make_sprite(32'h0001_0000, 32'h0001_0000, 32'h0, 16'sd0, 4'b0011);
		rows[4].spr = make_sprite(32'h0, 32'h0002_0000, 32'h0000_8000, 16'sd0, 4'b0000);
		rows[5].spr = make_sprite(32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 16'sh7fff, 4'b0100);
		rows[6].spr = make_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sh8000, 4'b1111);
		rows[7].spr = make_sprite(32'h7fff_ffff, 32'h0004_0000, 32'h0001_0000, 16'sd12868, 4'b1100);
		rows[8].spr = make_sprite(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, -16'sd12868, 4'b1000);
		rows[9].spr = make_sprite(32'h0004_0000, 32'hffff_0000, 32'h0002_0000, 16'sd25736, 4'b0101);
		rows[10].spr = make_sprite(32'h0001_0000, 32'h7fff_ffff, 32'h0, 16'sd100, 4'b0000);
		rows[10].tw = 15'd16384; rows[10].th = 15'd16384;
		rows[11].spr = make_sprite(32'h0100_0000, 32'h0001_0000, 32'h0, 16'sd0, 4'b0100);
		rows[11].tw = 15'd0; rows[11].th = 15'd32767;
		rows[12].spr = make_sprite(32'h0100_0000, 32'h0001_0000, 32'h0080_0000, 16'sd1, 4'b0110);
		rows[12].tw = 15'd32767; rows[12].th = 15'd0;
		rows[13].spr = make_sprite(32'hffff_0000, 32'h0010_0000, 32'h7fff_ffff, -16'sd1, 4'b1001);
		rows[13].tw = 15'd3; rows[13].th = 15'd5;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the table, changing registers only when the pipe is empty.
		foreach (rows[i]) begin
			r = rows[i];
			if (r.tw != cur_tw || r.th != cur_th) begin
				drain();
				write_reg(REG_TEX_W, r.tw);
				write_reg(REG_TEX_H, r.th);
			end
			send_sprite(r.spr);
			// The four corners of this sprite are the newest entries of the queue.
			row_corners = pending_corners.size() - 4;
			if (r.has_known) pending_corners[row_corners] = r.known;
		end

		// Random sprites in phases, each with its own texture size.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_TEX_W, ph < 5 ? tws[ph] : 15'($urandom_range(1, 16384)));
			write_reg(REG_TEX_H, ph < 5 ? tws[4 - ph] : 15'($urandom_range(1, 16384)));
			no_idle = (ph == 5);
			for (int k = 0; k < N_RANDOM / 6; k++) send_sprite(rand_sprite());
		end

		// Drain and report.
		drain();
		$display("Covered %0d sprites, %0d corners, several texture sizes incl. extremes.",
			sprites_sent, corners_seen);
		if (mismatches == 0) begin
			$display("sprite_quad_corner_generator_core test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("sprite_quad_corner_generator_core test failed");
		end
		$finish;
	end
endmodule
